/* rtl/mtcc_pkg.sv */
// ============================================================================
// mtcc_pkg: markup tag character classifier package
// Role and parse state codes, tag delimiters and the name character test.
// ============================================================================
`default_nettype none

package mtcc_pkg;

	typedef enum logic [2:0] {
		ROLE_IGNORE = 3'd0,
		ROLE_SLASH  = 3'd1,
		ROLE_ELEM   = 3'd2,
		ROLE_ANAME  = 3'd3,
		ROLE_AVALUE = 3'd4,
		ROLE_ADONE  = 3'd5,
		ROLE_TDONE  = 3'd6
	} role_t;

	typedef enum logic [2:0] {
		ST_FIRST = 3'd0,
		ST_NAME  = 3'd1,
		ST_GAP   = 3'd2,
		ST_ANAME = 3'd3,
		ST_QUOTE = 3'd4,
		ST_VALUE = 3'd5
	} state_t;

	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_UNDER = 8'h5F;

	function automatic logic is_name_char(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
			(c >= 8'h61 && c <= 8'h7A) || (c == CH_UNDER);
	endfunction

endpackage

`default_nettype wire

/* rtl/mtcc_in_if.sv */
// ============================================================================
// mtcc_in_if: character input channel
// Valid/ready channel carrying one raw tag character and its end-of-buffer mark.
// ============================================================================
`default_nettype none

interface mtcc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       last_in_buffer;

	modport source (output valid, output ch, output last_in_buffer, input ready);
	modport sink   (input valid, input ch, input last_in_buffer, output ready);
endinterface

`default_nettype wire

/* rtl/mtcc_out_if.sv */
// ============================================================================
// mtcc_out_if: labelled character output channel
// Valid/ready channel carrying the role, the character and the end-tag flag.
// ============================================================================
`default_nettype none

interface mtcc_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] role;
	logic [7:0] ch_out;
	logic       is_closing_tag;

	modport source (output valid, output role, output ch_out, output is_closing_tag,
		input ready);
	modport sink   (input valid, input role, input ch_out, input is_closing_tag,
		output ready);
endinterface

`default_nettype wire

/* rtl/markup_tag_char_classifier.sv */
// ============================================================================
// markup_tag_char_classifier: tag character role labeller
// Labels each character after '<' with its role in the tag, one beat per beat.
// ============================================================================
// Stages: input register, then result register; the parse state decode sits
//   between them.
// Throughput: 1 character per cycle while labels.ready does not stall the output.
// Reset: arst_n clears both stages' valid bits, the parse state and the
//   end-tag flag; payload registers are not reset.
`default_nettype none

module markup_tag_char_classifier (
	input  wire logic  clk,
	input  wire logic  arst_n,
	mtcc_in_if.sink    chars,
	mtcc_out_if.source labels
);
	import mtcc_pkg::*;

	logic       valid_s1;
	logic [7:0] ch_s1;
	logic       last_s1;

	logic       valid_s2;
	role_t      role_s2;
	logic [7:0] ch_s2;
	logic       closing_s2;

	state_t     state_q;
	logic       closing_q;

	logic       adv_s2;
	logic       adv_s1;
	role_t      role_d;
	state_t     next_d;
	logic       flag_d;
	logic       restart;

	assign adv_s2      = !valid_s2 || labels.ready;
	assign adv_s1      = valid_s1 && adv_s2;
	assign chars.ready = !valid_s1 || adv_s2;

	always_comb begin
		role_d = ROLE_IGNORE;
		next_d = state_q;
		flag_d = closing_q;
		unique case (state_q)
			ST_NAME: begin
				if (ch_s1 == CH_GT) role_d = ROLE_TDONE;
				else if (is_name_char(ch_s1)) role_d = ROLE_ELEM;
				else next_d = ST_GAP;
			end
			ST_GAP: begin
				if (ch_s1 == CH_GT) role_d = ROLE_TDONE;
				else if (is_name_char(ch_s1)) begin
					role_d = ROLE_ANAME;
					next_d = ST_ANAME;
				end
			end
			ST_ANAME: begin
				if (ch_s1 == CH_EQ) next_d = ST_QUOTE;
				else role_d = ROLE_ANAME;
			end
			ST_QUOTE: begin
				if (ch_s1 == CH_QUOTE) next_d = ST_VALUE;
			end
			ST_VALUE: begin
				if (ch_s1 == CH_QUOTE) begin
					role_d = ROLE_ADONE;
					next_d = ST_GAP;
				end else role_d = ROLE_AVALUE;
			end
			default: begin
				if (ch_s1 == CH_SLASH) begin
					role_d = ROLE_SLASH;
					flag_d = 1'b1;
					next_d = ST_FIRST;
				end else begin
					role_d = ROLE_ELEM;
					next_d = ST_NAME;
				end
			end
		endcase
	end

	assign restart = (role_d == ROLE_TDONE) || last_s1;

	// advance the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			ch_s1   <= chars.ch;
			last_s1 <= chars.last_in_buffer;
		end
	end

	// update parse state on each classified beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_FIRST;
			closing_q <= 1'b0;
		end else if (adv_s1) begin
			state_q   <= restart ? ST_FIRST : next_d;
			closing_q <= restart ? 1'b0 : flag_d;
		end
	end

	// hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			role_s2    <= role_d;
			ch_s2      <= ch_s1;
			closing_s2 <= flag_d;
		end
	end

	assign labels.valid          = valid_s2;
	assign labels.role           = role_s2;
	assign labels.ch_out         = ch_s2;
	assign labels.is_closing_tag = closing_s2;

	a_tag_done_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && role_d == ROLE_TDONE) |=> (state_q == ST_FIRST && !closing_q))
		else $error("parse did not restart after tag done");

	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && last_s1) |=> (state_q == ST_FIRST && !closing_q))
		else $error("parse did not restart after last character");

	a_slash_flags_close: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && role_s2 == ROLE_SLASH) |-> closing_s2)
		else $error("close slash reported without end-tag flag");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !labels.ready) |=> (valid_s2 && $stable(ch_s2) && $stable(role_s2)))
		else $error("stalled result changed");

endmodule

`default_nettype wire
